@@ hw/rtl/dgps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dgps_pkg
// Shared types and constants of the dual position-sensor pose selector.
// ----------------------------------------------------------------------------
package dgps_pkg;

   // Heading units: 1/64 degree, one full turn
   localparam logic [15:0] FULL_TURN  = 16'd23040;
   localparam logic [15:0] HALF_TURN  = 16'd11520;
   localparam logic [16:0] TWO_TURNS  = 17'd46080;
   // A full turn is 2^TURN_SHIFT times TURN_ODD
   localparam int          TURN_SHIFT = 9;
   localparam int          TURN_ODD   = 45;

   // Configuration port
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAIN_RIGHT    = 3'd0,
      CSR_MAIN_FORWARD  = 3'd1,
      CSR_BACKUP_RIGHT  = 3'd2,
      CSR_BACKUP_FORWARD= 3'd3,
      CSR_MAIN_TRIM     = 3'd4,
      CSR_BACKUP_TRIM   = 3'd5,
      CSR_MIN_QUALITY   = 3'd6,
      CSR_SWITCH_MARGIN = 3'd7
   } csr_index_type;

   // One request: a reading from each sensor
   typedef struct packed {
      logic signed [15:0] main_x;
      logic signed [15:0] main_y;
      logic        [14:0] main_heading;
      logic        [6:0]  main_quality;
      logic signed [15:0] backup_x;
      logic signed [15:0] backup_y;
      logic        [14:0] backup_heading;
      logic        [6:0]  backup_quality;
   } req_payload_type;

   // One result: the chosen centre pose
   typedef struct packed {
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic        [14:0] pose_heading;
      logic               used_backup;
      logic               offset_valid;
   } rsp_payload_type;

   // Load enables of the sensor path stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // Selection decision carried beside the sensor paths
   typedef struct packed {
      logic both_usable;
      logic use_backup;
   } sel_flags_type;

   // Clamp an 18-bit signed value to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dgps_sine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dgps_sine
// Sine and cosine of an angle index from a quarter-wave Q14 table.
// ----------------------------------------------------------------------------
module dgps_sine
   import dgps_pkg::*;
#(
   parameter int ANGLE_STEPS = 1024
) (
   input  wire logic [$clog2(ANGLE_STEPS+1)-1:0] idx,
   output logic signed [15:0]                     sin_val,
   output logic signed [15:0]                     cos_val
);

   localparam int IDX_W  = $clog2(ANGLE_STEPS+1);
   localparam int QSTEPS = ANGLE_STEPS / 4;
   localparam int RW     = $clog2(QSTEPS+1);
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [IDX_W-1:0] Q1 = IDX_W'(QSTEPS);
   localparam logic [IDX_W-1:0] Q2 = IDX_W'(2*QSTEPS);
   localparam logic [IDX_W-1:0] Q3 = IDX_W'(3*QSTEPS);
   localparam logic [IDX_W-1:0] Q4 = IDX_W'(4*QSTEPS);

   typedef struct packed {
      logic          neg;
      logic [RW-1:0] addr;
   } quad_type;

   // Taylor series of sin(pi/2 * k/Q) in Q30, rounded to Q14
   function automatic logic [14:0] quarter_sine(input int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      x    = (HALF_PI_Q30 * longint'(k)) / QSTEPS;
      term = x;
      sum  = longint'(x);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 6;
      sum  = sum - longint'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 20;
      sum  = sum + longint'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 42;
      sum  = sum - longint'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 72;
      sum  = sum + longint'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 110;
      sum  = sum - longint'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 32768) >>> 16;
      if (sum > 16384) begin
         sum = 16384;
      end
      return 15'(sum);
   endfunction

   // Map a full-circle index to a table address and sign
   function automatic quad_type decode(input logic [IDX_W-1:0] i);
      quad_type d;
      if (i < Q1) begin
         d.neg  = 1'b0;
         d.addr = RW'(i);
      end else if (i < Q2) begin
         d.neg  = 1'b0;
         d.addr = RW'(Q2 - i);
      end else if (i < Q3) begin
         d.neg  = 1'b1;
         d.addr = RW'(i - Q2);
      end else begin
         d.neg  = 1'b1;
         d.addr = RW'(Q4 - i);
      end
      return d;
   endfunction

   logic [14:0]      quarter_rom [QSTEPS+1];
   logic [IDX_W-1:0] cos_idx;
   quad_type         sin_q;
   quad_type         cos_q;

   // Build the constant quarter-wave table
   for (genvar k = 0; k <= QSTEPS; k++) begin : g_rom
      assign quarter_rom[k] = quarter_sine(k);
   end

   // Cosine is sine a quarter turn ahead
   assign cos_idx = (idx >= Q3) ? (idx - Q3) : (idx + Q1);

   always_comb begin
      sin_q   = decode(idx);
      cos_q   = decode(cos_idx);
      sin_val = sin_q.neg ? -$signed({1'b0, quarter_rom[sin_q.addr]})
                          :  $signed({1'b0, quarter_rom[sin_q.addr]});
      cos_val = cos_q.neg ? -$signed({1'b0, quarter_rom[cos_q.addr]})
                          :  $signed({1'b0, quarter_rom[cos_q.addr]});
   end

endmodule
`default_nettype wire

@@ hw/rtl/dgps_sensor_path.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dgps_sensor_path
// Three-stage path for one sensor: trimmed heading and angle index, sine
// and cosine lookup with lever arm products, rounding to the centre position.
// ----------------------------------------------------------------------------
module dgps_sensor_path
   import dgps_pkg::*;
#(
   parameter int ANGLE_STEPS = 1024
) (
   input  wire logic               clock,
   input  wire stage_en_type       en,
   input  wire logic signed [15:0] raw_x,
   input  wire logic signed [15:0] raw_y,
   input  wire logic        [14:0] raw_heading,
   input  wire logic        [14:0] trim,
   input  wire logic signed [13:0] rgt,
   input  wire logic signed [13:0] fwd,
   output logic signed [15:0]      centre_x,
   output logic signed [15:0]      centre_y,
   output logic        [14:0]      heading
);

   localparam int IDX_W       = $clog2(ANGLE_STEPS+1);
   localparam int NUM_W       = $clog2(23040*ANGLE_STEPS + 23040);
   localparam int M_W         = NUM_W - TURN_SHIFT;
   localparam int RECIP_SHIFT = M_W + 6;
   localparam int RECIP_W     = RECIP_SHIFT - 5;
   localparam int PROD_W      = M_W + RECIP_W;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << RECIP_SHIFT) + TURN_ODD - 1) / TURN_ODD;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic [IDX_W-1:0]   IDX_FULL = IDX_W'(ANGLE_STEPS);

   // Stage 1
   logic        [M_W-1:0]   m1_ff,  m1_in;
   logic        [14:0]      h1_ff,  h1_in;
   logic signed [15:0]      x1_ff,  y1_ff;
   // Stage 2
   logic signed [15:0]      sin2_ff, cos2_ff;
   logic        [14:0]      h2_ff;
   logic signed [15:0]      x2_ff,  y2_ff;
   // Stage 3
   logic signed [30:0]      dx3_ff, dx3_in;
   logic signed [30:0]      dy3_ff, dy3_in;
   logic        [14:0]      h3_ff;
   logic signed [15:0]      x3_ff,  y3_ff;

   logic        [15:0]      trim_sum;
   logic        [NUM_W-1:0] angle_num;
   logic        [PROD_W-1:0] recip_prod;
   logic        [IDX_W-1:0] idx_raw;
   logic        [IDX_W-1:0] idx;
   logic signed [15:0]      sin_v, cos_v;
   logic signed [29:0]      p_rc, p_fs, p_fc, p_rs;
   logic signed [30:0]      dx_rnd, dy_rnd;
   logic signed [16:0]      dx, dy;

   // Add the trim and wrap into one turn
   always_comb begin
      trim_sum = {1'b0, raw_heading} + {1'b0, trim};
      if ({1'b0, trim_sum} >= TWO_TURNS) begin
         h1_in = 15'(trim_sum - 16'(TWO_TURNS));
      end else if (trim_sum >= FULL_TURN) begin
         h1_in = 15'(trim_sum - FULL_TURN);
      end else begin
         h1_in = trim_sum[14:0];
      end
      angle_num = NUM_W'(h1_in) * NUM_W'(ANGLE_STEPS) + NUM_W'(HALF_TURN);
      m1_in     = angle_num[NUM_W-1:TURN_SHIFT];
   end

   // Finish the divide by a full turn with a reciprocal, wrap the index
   always_comb begin
      recip_prod = PROD_W'(m1_ff) * PROD_W'(RECIP);
      idx_raw    = recip_prod[RECIP_SHIFT +: IDX_W];
      idx        = (idx_raw == IDX_FULL) ? '0 : idx_raw;
   end

   dgps_sine #(
      .ANGLE_STEPS (ANGLE_STEPS)
   ) u_sine (
      .idx     (idx),
      .sin_val (sin_v),
      .cos_val (cos_v)
   );

   // Rotate the lever arm by the heading
   always_comb begin
      p_rc   = rgt * cos2_ff;
      p_fs   = fwd * sin2_ff;
      p_fc   = fwd * cos2_ff;
      p_rs   = rgt * sin2_ff;
      dx3_in = 31'(p_rc) + 31'(p_fs);
      dy3_in = 31'(p_fc) - 31'(p_rs);
   end

   // Round half up to whole units and move to the centre
   always_comb begin
      dx_rnd   = dx3_ff + 31'sd8192;
      dy_rnd   = dy3_ff + 31'sd8192;
      dx       = dx_rnd[30:14];
      dy       = dy_rnd[30:14];
      centre_x = sat16(18'(x3_ff) - 18'(dx));
      centre_y = sat16(18'(y3_ff) - 18'(dy));
      heading  = h3_ff;
   end

   // Advance the stage registers
   always_ff @(posedge clock) begin
      if (en.s1) begin
         m1_ff <= m1_in;
         h1_ff <= h1_in;
         x1_ff <= raw_x;
         y1_ff <= raw_y;
      end
      if (en.s2) begin
         sin2_ff <= sin_v;
         cos2_ff <= cos_v;
         h2_ff   <= h1_ff;
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
      end
      if (en.s3) begin
         dx3_ff <= dx3_in;
         dy3_ff <= dy3_in;
         h3_ff  <= h2_ff;
         x3_ff  <= x2_ff;
         y3_ff  <= y2_ff;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/dual_gps_pose_selector_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dual_gps_pose_selector_top
// Moves the readings of a main and a backup position sensor to the robot
// centre, keeps the backup-to-main offset and picks the pose to report.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid / req_stall  req_payload_type (both readings)
//  rsp_      out        rsp_valid / rsp_stall  rsp_payload_type (chosen pose)
//  csr_      in         csr_write_en           csr_index, csr_wdata
//
//  One request per cycle while req_stall is low; a result shows on rsp_ after
//  its request has passed the input register, the three sensor-path stages
//  and the result register.
//  The stage ready chain lets bubbles close up while a result waits on
//  rsp_stall; requests stall only when every stage and the result register are full.
//  Reset clears all stage valid bits, the captured offset and loads the
//  register defaults.
// ----------------------------------------------------------------------------
module dual_gps_pose_selector_top
   import dgps_pkg::*;
#(
   parameter int ANGLE_STEPS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic signed [13:0] mro_ff, mfo_ff, bro_ff, bfo_ff;
   logic        [14:0] mtrim_ff, btrim_ff;
   logic        [6:0]  minq_ff, margin_ff;

   // Captured backup-to-main offset
   logic signed [16:0] off_x_ff, off_y_ff;
   logic               cap_ff;

   // Stage control and payload
   logic [3:0]         stage_valid_ff;
   logic               rsp_valid_ff;
   logic [4:0]         stage_ready;
   req_payload_type    req_ff;
   sel_flags_type      flags0_in, flags1_ff, flags2_ff, flags3_ff;
   rsp_payload_type    rsp_data_ff, rsp_data_in;
   stage_en_type       path_en;

   logic               main_ok, backup_ok;
   logic        [7:0]  main_plus_margin;
   logic signed [15:0] mx, my, bx, by;
   logic        [14:0] mh, bh;
   logic signed [16:0] off_x_use, off_y_use;
   logic               cap_next;
   logic signed [15:0] bx_adj, by_adj;

   // Ready chain from the result register back to the input register
   always_comb begin
      stage_ready[4] = !rsp_valid_ff || !rsp_stall;
      stage_ready[3] = !stage_valid_ff[3] || stage_ready[4];
      stage_ready[2] = !stage_valid_ff[2] || stage_ready[3];
      stage_ready[1] = !stage_valid_ff[1] || stage_ready[2];
      stage_ready[0] = !stage_valid_ff[0] || stage_ready[1];
      path_en.s1     = stage_ready[1];
      path_en.s2     = stage_ready[2];
      path_en.s3     = stage_ready[3];
   end

   assign req_stall = !stage_ready[0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decide usability and the switch early; registers hold while busy
   always_comb begin
      main_ok               = req_ff.main_quality >= minq_ff;
      backup_ok             = req_ff.backup_quality >= minq_ff;
      main_plus_margin      = {1'b0, req_ff.main_quality} + {1'b0, margin_ff};
      flags0_in.both_usable = main_ok && backup_ok;
      flags0_in.use_backup  = backup_ok &&
                              (!main_ok || ({1'b0, req_ff.backup_quality} >= main_plus_margin));
   end

   dgps_sensor_path #(
      .ANGLE_STEPS (ANGLE_STEPS)
   ) u_main_path (
      .clock       (clock),
      .en          (path_en),
      .raw_x       (req_ff.main_x),
      .raw_y       (req_ff.main_y),
      .raw_heading (req_ff.main_heading),
      .trim        (mtrim_ff),
      .rgt         (mro_ff),
      .fwd         (mfo_ff),
      .centre_x    (mx),
      .centre_y    (my),
      .heading     (mh)
   );

   dgps_sensor_path #(
      .ANGLE_STEPS (ANGLE_STEPS)
   ) u_backup_path (
      .clock       (clock),
      .en          (path_en),
      .raw_x       (req_ff.backup_x),
      .raw_y       (req_ff.backup_y),
      .raw_heading (req_ff.backup_heading),
      .trim        (btrim_ff),
      .rgt         (bro_ff),
      .fwd         (bfo_ff),
      .centre_x    (bx),
      .centre_y    (by),
      .heading     (bh)
   );

   // Capture the offset, apply it to the backup, pick the pose
   always_comb begin
      if (flags3_ff.both_usable) begin
         off_x_use = 17'(mx) - 17'(bx);
         off_y_use = 17'(my) - 17'(by);
      end else begin
         off_x_use = off_x_ff;
         off_y_use = off_y_ff;
      end
      cap_next = cap_ff || flags3_ff.both_usable;
      if (cap_next) begin
         bx_adj = sat16(18'(bx) + 18'(off_x_use));
         by_adj = sat16(18'(by) + 18'(off_y_use));
      end else begin
         bx_adj = bx;
         by_adj = by;
      end
      rsp_data_in.pose_x       = flags3_ff.use_backup ? bx_adj : mx;
      rsp_data_in.pose_y       = flags3_ff.use_backup ? by_adj : my;
      rsp_data_in.pose_heading = flags3_ff.use_backup ? bh : mh;
      rsp_data_in.used_backup  = flags3_ff.use_backup;
      rsp_data_in.offset_valid = cap_next;
   end

   // Control state: valid bits, offset, configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         off_x_ff       <= '0;
         off_y_ff       <= '0;
         cap_ff         <= 1'b0;
         mro_ff         <= 14'sd1024;
         mfo_ff         <= -14'sd1792;
         bro_ff         <= 14'sd0;
         bfo_ff         <= 14'sd1792;
         mtrim_ff       <= 15'd11520;
         btrim_ff       <= 15'd0;
         minq_ff        <= 7'd75;
         margin_ff      <= 7'd5;
      end else begin
         if (stage_ready[0]) begin
            stage_valid_ff[0] <= req_valid;
         end
         if (stage_ready[1]) begin
            stage_valid_ff[1] <= stage_valid_ff[0];
         end
         if (stage_ready[2]) begin
            stage_valid_ff[2] <= stage_valid_ff[1];
         end
         if (stage_ready[3]) begin
            stage_valid_ff[3] <= stage_valid_ff[2];
         end
         if (stage_ready[4]) begin
            rsp_valid_ff <= stage_valid_ff[3];
         end
         // Latch the offset as the request leaves the last stage
         if (stage_ready[4] && stage_valid_ff[3] && flags3_ff.both_usable) begin
            off_x_ff <= off_x_use;
            off_y_ff <= off_y_use;
            cap_ff   <= 1'b1;
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_MAIN_RIGHT:     mro_ff    <= csr_wdata[13:0];
               CSR_MAIN_FORWARD:   mfo_ff    <= csr_wdata[13:0];
               CSR_BACKUP_RIGHT:   bro_ff    <= csr_wdata[13:0];
               CSR_BACKUP_FORWARD: bfo_ff    <= csr_wdata[13:0];
               CSR_MAIN_TRIM:      mtrim_ff  <= csr_wdata[14:0];
               CSR_BACKUP_TRIM:    btrim_ff  <= csr_wdata[14:0];
               CSR_MIN_QUALITY:    minq_ff   <= csr_wdata[6:0];
               CSR_SWITCH_MARGIN:  margin_ff <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         req_ff <= req_data;
      end
      if (stage_ready[1]) begin
         flags1_ff <= flags0_in;
      end
      if (stage_ready[2]) begin
         flags2_ff <= flags1_ff;
      end
      if (stage_ready[3]) begin
         flags3_ff <= flags2_ff;
      end
      if (stage_ready[4]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Once captured, the offset stays valid
   a_cap_sticky: assert property (@(posedge clock) disable iff (reset)
      cap_ff |=> cap_ff)
      else $error("captured offset flag dropped");

   // A result that reports a valid offset implies the capture flag is set
   a_rsp_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.offset_valid) |-> cap_ff)
      else $error("result offset flag without capture");

   // Requests stall only when every stage is full and the result is held
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (req_stall) |-> (&stage_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // Reported heading is always within one turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.pose_heading} < FULL_TURN))
      else $error("pose heading out of range");

endmodule
`default_nettype wire
